FILE: design/gbs_pkg.sv
// ----------------------------------------------------------------------------
// gbs_pkg: shared types and constants for greedy box suppression
// Field widths, the packed layout of one kept-box memory word, and the result
// word that the overlap unit hands back to the sequencer.
// ----------------------------------------------------------------------------
package gbs_pkg;

  localparam int COORD_W   = 17;  // signed Q12.4 coordinate
  localparam int SPAN_W    = 19;  // edge difference plus one pixel
  localparam int AREA_W    = 36;  // signed Q27.8 area
  localparam int PROD_W    = 38;  // full span-by-span product
  localparam int INTER_W   = 35;  // non-negative intersection area
  localparam int UNION_W   = 38;  // kept area plus new area minus intersection
  localparam int THR_W     = 16;  // Q0.16 overlap threshold
  localparam int SCALED_W  = 55;  // threshold times union
  localparam int LIMIT_W   = 7;
  localparam int INDEX_W   = 10;
  localparam int ORD_W     = 6;
  localparam int ONE_PIXEL = 16;

  // One kept-box word: {x1, y1, x2, y2, area}
  localparam int ENTRY_W   = 4 * COORD_W + AREA_W;
  localparam int X1_LSB    = 3 * COORD_W + AREA_W;
  localparam int Y1_LSB    = 2 * COORD_W + AREA_W;
  localparam int X2_LSB    = COORD_W + AREA_W;
  localparam int Y2_LSB    = AREA_W;

  localparam logic [THR_W-1:0]   THR_RESET   = 16'd45875;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [AREA_W-1:0]  area_t;

  // Word returned by the overlap unit
  typedef struct packed {
    logic  area_valid;  // new-box area is ready
    area_t area;
    logic  test_valid;  // one kept-box comparison has finished
    logic  overlap;     // that kept box suppresses the new box
  } gbs_result_t;

endpackage

FILE: design/gbs_ram.sv
// ----------------------------------------------------------------------------
// gbs_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/gbs_iou_unit.sv
// ----------------------------------------------------------------------------
// gbs_iou_unit: shared span/multiply/compare pipe
// Either computes the area of the new box or tests one kept box for an
// intersection over union above the threshold, one operation per cycle.
// ----------------------------------------------------------------------------
module gbs_iou_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      area_mode,
  input  logic [gbs_pkg::THR_W-1:0] thr,
  input  gbs_pkg::coord_t           x1,
  input  gbs_pkg::coord_t           y1,
  input  gbs_pkg::coord_t           x2,
  input  gbs_pkg::coord_t           y2,
  input  gbs_pkg::area_t            new_area,
  input  logic [gbs_pkg::ENTRY_W-1:0] entry,
  output gbs_pkg::gbs_result_t      res
);
  import gbs_pkg::*;

  localparam logic signed [SPAN_W-1:0] PX = SPAN_W'(ONE_PIXEL);

  coord_t kx1, ky1, kx2, ky2;
  coord_t lo_x, lo_y, hi_x, hi_y;
  logic signed [SPAN_W-1:0] dx, dy, w_next, h_next;

  // stage A: spans
  logic                      v_a, mode_a;
  logic signed [SPAN_W-1:0]  w_a, h_a;
  area_t                     karea_a;
  // stage B: product
  logic                      v_b, mode_b;
  logic signed [PROD_W-1:0]  prod_b;
  area_t                     karea_b;
  // stage C: union
  logic                      v_c;
  logic signed [UNION_W-1:0] union_c;
  logic [INTER_W-1:0]        inter_c;
  // stage D: scaled union
  logic                      v_d, pos_d;
  logic signed [SCALED_W-1:0] scaled_d;
  logic [INTER_W-1:0]        inter_d;
  // stage E: compare
  logic                      v_e, ovl_e;

  assign kx1 = $signed(entry[X1_LSB +: COORD_W]);
  assign ky1 = $signed(entry[Y1_LSB +: COORD_W]);
  assign kx2 = $signed(entry[X2_LSB +: COORD_W]);
  assign ky2 = $signed(entry[Y2_LSB +: COORD_W]);

  always_comb begin
    lo_x = (x1 > kx1) ? x1 : kx1;
    lo_y = (y1 > ky1) ? y1 : ky1;
    hi_x = (x2 < kx2) ? x2 : kx2;
    hi_y = (y2 < ky2) ? y2 : ky2;
    if (area_mode) begin
      dx     = SPAN_W'(x2) - SPAN_W'(x1) + PX;
      dy     = SPAN_W'(y2) - SPAN_W'(y1) + PX;
      w_next = dx;
      h_next = dy;
    end else begin
      dx     = SPAN_W'(hi_x) - SPAN_W'(lo_x) + PX;
      dy     = SPAN_W'(hi_y) - SPAN_W'(lo_y) + PX;
      // clamp: disjoint boxes share nothing
      w_next = dx[SPAN_W-1] ? '0 : dx;
      h_next = dy[SPAN_W-1] ? '0 : dy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
      v_e <= 1'b0;
    end else begin
      v_a <= start;
      v_b <= v_a;
      v_c <= v_b & ~mode_b;
      v_d <= v_c;
      v_e <= v_d;
    end
  end

  always_ff @(posedge clk) begin
    mode_a   <= area_mode;
    w_a      <= w_next;
    h_a      <= h_next;
    karea_a  <= $signed(entry[AREA_W-1:0]);

    mode_b   <= mode_a;
    prod_b   <= w_a * h_a;
    karea_b  <= karea_a;

    union_c  <= UNION_W'(karea_b) + UNION_W'(new_area) - UNION_W'(prod_b);
    inter_c  <= prod_b[INTER_W-1:0];

    scaled_d <= $signed({1'b0, thr}) * union_c;
    pos_d    <= (union_c > UNION_W'(0));
    inter_d  <= inter_c;

    ovl_e    <= pos_d && ($signed({1'b0, inter_d, 16'b0}) > scaled_d);
  end

  assign res.area_valid = v_b & mode_b;
  assign res.area       = prod_b[AREA_W-1:0];
  assign res.test_valid = v_e;
  assign res.overlap    = ovl_e;

endmodule

FILE: design/greedy_box_suppression_unit.sv
// ----------------------------------------------------------------------------
// greedy_box_suppression_unit: greedy non-maximum suppression by IoU
// Accepts score-sorted boxes one word at a time and emits each box that
// survives suppression against the boxes already kept in its set.
// ----------------------------------------------------------------------------
// Boxes arrive already sorted by descending score; first_of_set empties the
// kept list and restarts the position count. A box is kept when fewer than
// keep_limit boxes have been kept (capped at MAX_KEEP) and no kept box
// overlaps it with inter * 2^16 > overlap_threshold * union (union <= 0 counts
// as no overlap). Each kept box yields one output word carrying its position
// in the set and how many boxes were kept before it. Boxes from position
// MAX_BOXES of a set on are dropped. Boxes are taken one word at a time. A box
// dropped up front (limit reached or set too long) never leaves the idle state;
// otherwise, with N boxes already kept in the set, the new box's area is computed,
// the N kept boxes are scanned and the pipe is drained, and a kept box then waits
// in the emit state through any output stall; an empty kept list skips the scan.
// The scan over the kept-box memory issues one registered read and one overlap
// test per cycle into a five-stage shared multiply/compare pipe, which also
// computes the new box's area first. Kept-box memory needs no clearing: only
// entries below the kept count are ever read.
// ----------------------------------------------------------------------------
module greedy_box_suppression_unit #(
  parameter int MAX_KEEP  = 64,
  parameter int MAX_BOXES = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // box input
  input  logic                        in_valid,
  output logic                        in_stall,
  input  gbs_pkg::coord_t             box_x1,
  input  gbs_pkg::coord_t             box_y1,
  input  gbs_pkg::coord_t             box_x2,
  input  gbs_pkg::coord_t             box_y2,
  input  logic                        first_of_set,
  // kept box output
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [gbs_pkg::INDEX_W-1:0] kept_index,
  output logic [gbs_pkg::ORD_W-1:0]   kept_ordinal,
  output gbs_pkg::coord_t             kept_x1,
  output gbs_pkg::coord_t             kept_y1,
  output gbs_pkg::coord_t             kept_x2,
  output gbs_pkg::coord_t             kept_y2
);
  import gbs_pkg::*;

  localparam int KW = $clog2(MAX_KEEP + 1);           // kept count
  localparam int AW = MAX_KEEP > 1 ? $clog2(MAX_KEEP) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);          // box position
  localparam int IW = CW > INDEX_W ? CW : INDEX_W;
  localparam int OW = KW > ORD_W ? KW : ORD_W;

  localparam logic REG_THRESHOLD  = 1'b0;
  localparam logic REG_KEEP_LIMIT = 1'b1;

  typedef enum logic [6:0] {
    ST_IDLE       = 7'b0000001,
    ST_AREA_ISSUE = 7'b0000010,
    ST_AREA_WAIT  = 7'b0000100,
    ST_SCAN       = 7'b0001000,
    ST_DRAIN      = 7'b0010000,
    ST_DECIDE     = 7'b0100000,
    ST_EMIT       = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [THR_W-1:0]   thr;
  logic [LIMIT_W-1:0] keep_limit;
  logic               cfg_write;

  logic [KW-1:0] kept_total;
  logic [CW-1:0] box_counter;
  logic [CW-1:0] pos;
  logic [KW-1:0] ord;
  logic [AW-1:0] scan_idx;
  logic [KW-1:0] done_cnt;
  logic          rd_pending;
  logic          overlap_any;
  area_t         new_area;
  coord_t        bx1, by1, bx2, by2;

  logic               accept;
  logic [KW-1:0]      tot_eff;
  logic [CW-1:0]      pos_eff;
  logic [LIMIT_W-1:0] limit_eff;
  logic               skip;
  logic               scan_rd;
  logic               unit_start;
  logic               unit_area_mode;
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_rdata;
  gbs_result_t        res;
  logic [IW-1:0]      pos_ext;
  logic [OW-1:0]      ord_ext;

  // --------------------------------------------------------------------------
  // Configuration registers; decode by word address only
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr        <= THR_RESET;
      keep_limit <= LIMIT_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_THRESHOLD:  thr        <= pwdata[THR_W-1:0];
        REG_KEEP_LIMIT: keep_limit <= pwdata[LIMIT_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_THRESHOLD:  prdata = 32'(thr);
      REG_KEEP_LIMIT: prdata = 32'(keep_limit);
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Front end: a new set clears the count before this box is placed
  // --------------------------------------------------------------------------
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    tot_eff   = first_of_set ? '0 : kept_total;
    pos_eff   = first_of_set ? '0 : box_counter;
    limit_eff = (keep_limit < LIMIT_W'(MAX_KEEP)) ? keep_limit : LIMIT_W'(MAX_KEEP);
    // drop up front: set too long or keep limit already reached
    skip      = (pos_eff >= CW'(MAX_BOXES)) || (LIMIT_W'(tot_eff) >= limit_eff);
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && !skip) begin
          state_next = ST_AREA_ISSUE;
        end
      end
      ST_AREA_ISSUE: state_next = ST_AREA_WAIT;
      ST_AREA_WAIT: begin
        if (res.area_valid) begin
          state_next = (kept_total == '0) ? ST_DECIDE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (KW'(scan_idx) == kept_total - 1'b1) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (res.test_valid && (KW'(done_cnt + 1'b1) == kept_total)) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: state_next = overlap_any ? ST_IDLE : ST_EMIT;
      ST_EMIT: begin
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      kept_total  <= '0;
      box_counter <= '0;
      rd_pending  <= 1'b0;
    end else begin
      state      <= state_next;
      rd_pending <= scan_rd;
      if (accept) begin
        kept_total  <= tot_eff;
        // hold at the cap: later boxes of the set are all dropped
        box_counter <= (pos_eff >= CW'(MAX_BOXES)) ? pos_eff : CW'(pos_eff + 1'b1);
      end else if (state == ST_DECIDE && !overlap_any) begin
        kept_total <= kept_total + 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      bx1 <= box_x1;
      by1 <= box_y1;
      bx2 <= box_x2;
      by2 <= box_y2;
      pos <= pos_eff;
    end
    if (res.area_valid) begin
      new_area <= res.area;
    end
    if (state == ST_AREA_WAIT) begin
      scan_idx    <= '0;
      done_cnt    <= '0;
      overlap_any <= 1'b0;
    end else begin
      if (scan_rd) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (res.test_valid) begin
        done_cnt    <= done_cnt + 1'b1;
        overlap_any <= overlap_any | res.overlap;
      end
    end
    if (state == ST_DECIDE) begin
      ord <= kept_total;
    end
  end

  // --------------------------------------------------------------------------
  // Kept-box memory and the shared overlap unit
  // --------------------------------------------------------------------------
  assign scan_rd        = (state == ST_SCAN);
  assign ram_we         = (state == ST_DECIDE) && !overlap_any;
  assign unit_area_mode = (state == ST_AREA_ISSUE);
  assign unit_start     = unit_area_mode | rd_pending;

  gbs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_KEEP)
  ) u_kept_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (kept_total[AW-1:0]),
    .wdata ({bx1, by1, bx2, by2, new_area}),
    .re    (scan_rd),
    .raddr (scan_idx),
    .rdata (ram_rdata)
  );

  gbs_iou_unit u_iou (
    .clk       (clk),
    .rst       (rst),
    .start     (unit_start),
    .area_mode (unit_area_mode),
    .thr       (thr),
    .x1        (bx1),
    .y1        (by1),
    .x2        (bx2),
    .y2        (by2),
    .new_area  (new_area),
    .entry     (ram_rdata),
    .res       (res)
  );

  // --------------------------------------------------------------------------
  // Output word: held by the datapath registers while in the emit state
  // --------------------------------------------------------------------------
  assign pos_ext      = IW'(pos);
  assign ord_ext      = OW'(ord);
  assign out_valid    = (state == ST_EMIT);
  assign kept_index   = pos_ext[INDEX_W-1:0];
  assign kept_ordinal = ord_ext[ORD_W-1:0];
  assign kept_x1      = bx1;
  assign kept_y1      = by1;
  assign kept_x2      = bx2;
  assign kept_y2      = by2;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_emit_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while an output word is pending");

  a_kept_bound: assert property (@(posedge clk) disable iff (rst)
    kept_total <= KW'(MAX_KEEP))
    else $error("kept count above capacity");

  a_counter_bound: assert property (@(posedge clk) disable iff (rst)
    box_counter <= CW'(MAX_BOXES))
    else $error("box position counter past saturation");

  a_test_in_scan: assert property (@(posedge clk) disable iff (rst)
    res.test_valid |-> (state == ST_SCAN || state == ST_DRAIN))
    else $error("overlap result outside the scan");

endmodule

FILE: test/gbs_tb_pkg.sv
// ----------------------------------------------------------------------------
// gbs_tb_pkg: register map of the suppression unit's configuration port
// Byte addresses of the two registers, shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
package gbs_tb_pkg;

  localparam logic [2:0] ADDR_THRESHOLD  = 3'd0;
  localparam logic [2:0] ADDR_KEEP_LIMIT = 3'd4;

endpackage

FILE: test/gbs_checker.sv
// ----------------------------------------------------------------------------
// gbs_checker: prediction and comparison for greedy box suppression
// Watches the register port and both word channels, runs its own suppression
// model on every accepted box and compares each accepted kept-box word, field
// by field, against the oldest predicted word.
// ----------------------------------------------------------------------------
module gbs_checker
  import gbs_pkg::*;
  import gbs_tb_pkg::*;
#(
  parameter int MAX_KEEP  = 64,
  parameter int MAX_BOXES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  coord_t             box_x1,
  input  coord_t             box_y1,
  input  coord_t             box_x2,
  input  coord_t             box_y2,
  input  logic               first_of_set,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [INDEX_W-1:0] kept_index,
  input  logic [ORD_W-1:0]   kept_ordinal,
  input  coord_t             kept_x1,
  input  coord_t             kept_y1,
  input  coord_t             kept_x2,
  input  coord_t             kept_y2,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [INDEX_W-1:0] pos;
    logic [ORD_W-1:0]   ord;
    coord_t             x1;
    coord_t             y1;
    coord_t             x2;
    coord_t             y2;
  } kept_word_t;

  // Model copy of the kept list and counters
  coord_t              held_x1 [MAX_KEEP];
  coord_t              held_y1 [MAX_KEEP];
  coord_t              held_x2 [MAX_KEEP];
  coord_t              held_y2 [MAX_KEEP];
  longint              held_area [MAX_KEEP];
  int                  held_count = 0;
  int                  box_pos = 0;
  logic [THR_W-1:0]    thr = THR_RESET;
  logic [LIMIT_W-1:0]  limit = LIMIT_RESET;
  kept_word_t          kept_expected [$];

  function automatic longint lmin(longint a, longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint lmax(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  // True when held box k overlaps the new box above the threshold
  function automatic bit suppressed_by(int k, longint x1, longint y1, longint x2,
                                       longint y2, longint area);
    longint w, h, inter, uni;
    w = lmax(0, lmin(x2, held_x2[k]) - lmax(x1, held_x1[k]) + ONE_PIXEL);
    h = lmax(0, lmin(y2, held_y2[k]) - lmax(y1, held_y1[k]) + ONE_PIXEL);
    inter = w * h;
    uni = held_area[k] + area - inter;
    if (uni <= 0)
      return 1'b0;
    return (inter * 65536) > (longint'(thr) * uni);
  endfunction

  function automatic void admit_box(coord_t bx1, coord_t by1, coord_t bx2,
                                    coord_t by2, logic first);
    longint     x1, y1, x2, y2, area;
    int         cap, pos, k;
    kept_word_t w;
    x1 = bx1;
    y1 = by1;
    x2 = bx2;
    y2 = by2;
    cap = (int'(limit) < MAX_KEEP) ? int'(limit) : MAX_KEEP;
    if (first) begin
      held_count = 0;
      box_pos = 0;
    end
    pos = box_pos;
    if (box_pos < MAX_BOXES)
      box_pos++;
    if (pos >= MAX_BOXES || held_count >= cap)
      return;
    area = (x2 - x1 + ONE_PIXEL) * (y2 - y1 + ONE_PIXEL);
    for (k = 0; k < held_count; k++)
      if (suppressed_by(k, x1, y1, x2, y2, area))
        return;
    held_x1[held_count] = bx1;
    held_y1[held_count] = by1;
    held_x2[held_count] = bx2;
    held_y2[held_count] = by2;
    held_area[held_count] = area;
    w.pos = pos[INDEX_W-1:0];
    w.ord = held_count[ORD_W-1:0];
    w.x1 = bx1;
    w.y1 = by1;
    w.x2 = bx2;
    w.y2 = by2;
    kept_expected.push_back(w);
    held_count++;
  endfunction

  function automatic void check_word(kept_word_t got);
    kept_word_t want;
    if (kept_expected.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("[%0t] kept word with nothing expected: idx=%0d ord=%0d box=(%0d,%0d,%0d,%0d)",
                 $time, got.pos, got.ord, got.x1, got.y1, got.x2, got.y2);
      return;
    end
    want = kept_expected.pop_front();
    if (got.pos !== want.pos || got.ord !== want.ord || got.x1 !== want.x1 ||
        got.y1 !== want.y1 || got.x2 !== want.x2 || got.y2 !== want.y2) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("[%0t] kept word mismatch: expected idx=%0d ord=%0d box=(%0d,%0d,%0d,%0d)",
                 $time, want.pos, want.ord, want.x1, want.y1, want.x2, want.y2);
        $display("[%0t]                     actual   idx=%0d ord=%0d box=(%0d,%0d,%0d,%0d)",
                 $time, got.pos, got.ord, got.x1, got.y1, got.x2, got.y2);
      end
    end
  endfunction

  // Predict before comparing, so an expectation made on this edge is in place
  always @(posedge clk) begin
    if (rst) begin
      held_count = 0;
      box_pos = 0;
      thr = THR_RESET;
      limit = LIMIT_RESET;
      kept_expected.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ADDR_THRESHOLD:  thr = pwdata[THR_W-1:0];
          ADDR_KEEP_LIMIT: limit = pwdata[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        admit_box(box_x1, box_y1, box_x2, box_y2, first_of_set);
      if (out_valid && !out_stall)
        check_word({kept_index, kept_ordinal, kept_x1, kept_y1, kept_x2, kept_y2});
    end
    pending = kept_expected.size();
  end

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the greedy box suppression unit
// Drives score-sorted box sets through the unit under a range of overlap
// thresholds and keep limits, with random idling on both word channels, and
// leaves all prediction and comparison to the checker beside the unit.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gbs_pkg::*;
  import gbs_tb_pkg::*;

  localparam int MAX_KEEP     = 64;
  localparam int MAX_BOXES    = 1024;
  // A box may scan up to MAX_KEEP kept entries plus the pipe, plus a stall
  localparam int DRAIN_CYCLES = 120;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_BOXES  = 58;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_stall;
  coord_t             box_x1;
  coord_t             box_y1;
  coord_t             box_x2;
  coord_t             box_y2;
  logic               first_of_set;
  logic               out_valid;
  logic               out_stall;
  logic [INDEX_W-1:0] kept_index;
  logic [ORD_W-1:0]   kept_ordinal;
  coord_t             kept_x1;
  coord_t             kept_y1;
  coord_t             kept_x2;
  coord_t             kept_y2;
  int                 fail_count;
  int                 pending;
  int                 cycle_count = 0;

  // Idling odds in percent per word (sender) and per cycle (receiver)
  int                 gap_pct = 0;
  int                 stall_pct = 0;

  greedy_box_suppression_unit #(
    .MAX_KEEP  (MAX_KEEP),
    .MAX_BOXES (MAX_BOXES)
  ) dut (.*);

  gbs_checker #(
    .MAX_KEEP  (MAX_KEEP),
    .MAX_BOXES (MAX_BOXES)
  ) checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: end the run if the unit hangs
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver stalls: random bursts of out_stall, never back to back
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  function automatic int rand_in(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 10;
      2:       return 30;
      default: return 60;
    endcase
  endfunction

  // Register write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic [2:0] addr, input int value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = value;
    @(posedge clk);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Present one box word and hold it until the unit takes it
  task automatic send_box(input int x1, y1, x2, y2, input bit first);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid = 1'b1;
    box_x1 = coord_t'(x1);
    box_y1 = coord_t'(y1);
    box_x2 = coord_t'(x2);
    box_y2 = coord_t'(y2);
    first_of_set = first;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Wait until every predicted word is out, then let a silent scan finish
  task automatic wait_idle();
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(input int thr, input int limit);
    in_valid = 1'b0;
    wait_idle();
    write_reg(ADDR_THRESHOLD, thr);
    write_reg(ADDR_KEEP_LIMIT, limit);
  endtask

  // Box jittered around a cluster center, so neighbors overlap by varying amounts
  task automatic send_near(input int cx, cy, input bit first);
    int x1, y1;
    x1 = cx + rand_in(-300, 300);
    y1 = cy + rand_in(-300, 300);
    send_box(x1, y1, x1 + rand_in(16, 3000), y1 + rand_in(16, 3000), first);
  endtask

  // One well-formed set around a few centers, with some raw noise words and
  // the odd set restart in the middle
  task automatic send_random_set(input int count);
    int cx [8];
    int cy [8];
    int centers, pick, roll, i;
    centers = rand_in(1, 8);
    for (i = 0; i < centers; i++) begin
      cx[i] = rand_in(-60000, 55000);
      cy[i] = rand_in(-60000, 55000);
    end
    for (i = 0; i < count; i++) begin
      roll = rand_in(0, 99);
      pick = rand_in(0, centers - 1);
      if (roll < 12)
        send_box($urandom, $urandom, $urandom, $urandom, i == 0 || roll < 2);
      else
        send_near(cx[pick], cy[pick], i == 0 || roll < 15);
    end
  endtask

  // Disjoint boxes on a grid: fills the kept list to its cap, then hits the limit
  task automatic send_grid_set(input int count);
    int i, x1, y1;
    for (i = 0; i < count; i++) begin
      x1 = -40000 + (i % 9) * 1024 + rand_in(0, 200);
      y1 = -40000 + (i / 9) * 1024 + rand_in(0, 200);
      send_box(x1, y1, x1 + rand_in(16, 700), y1 + rand_in(16, 700), i == 0);
    end
  endtask

  // Set longer than MAX_BOXES: mostly suppressed cluster boxes, a fresh disjoint
  // box now and then, and fresh boxes from the last counted position on, which
  // must be dropped once the position counter saturates
  task automatic send_long_set();
    int i, c, x1, y1, fresh_cell;
    fresh_cell = 0;
    for (i = 0; i < MAX_BOXES + 16; i++) begin
      if (i % 50 == 25 || i >= MAX_BOXES - 1) begin
        x1 = -60000 + (fresh_cell % 20) * 2048;
        y1 = -60000 + (fresh_cell / 20) * 2048;
        fresh_cell++;
        send_box(x1, y1, x1 + rand_in(16, 1500), y1 + rand_in(16, 1500), i == 0);
      end else begin
        c = rand_in(0, 3);
        x1 = 10000 + c * 8000 + rand_in(-64, 64);
        y1 = 10000 + c * 8000 + rand_in(-64, 64);
        send_box(x1, y1, x1 + rand_in(800, 1200), y1 + rand_in(800, 1200), i == 0);
      end
    end
  endtask

  initial begin
    int p, n, k;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = ADDR_THRESHOLD;
    pwdata = '0;
    in_valid = 1'b0;
    box_x1 = '0;
    box_y1 = '0;
    box_x2 = '0;
    box_y2 = '0;
    first_of_set = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    gap_pct = 25;
    stall_pct = 25;

    // Reset settings; the first set starts without a set flag
    send_box(0, 0, 160, 160, 1'b0);
    send_box(0, 0, 160, 160, 1'b0);                  // identical box, suppressed
    send_box(176, 0, 336, 160, 1'b0);                // touching edge, no overlap
    send_box(-65536, -65536, 65535, 65535, 1'b0);    // widest box
    send_box(65535, 65535, 65535, 65535, 1'b0);      // single pixel, top corner
    send_box(-65536, -65536, -65536, -65536, 1'b0);  // single pixel, bottom corner
    send_box(1000, 0, 900, 160, 1'b0);               // inverted width, negative area
    send_box(1000, 0, 900, 160, 1'b0);               // negative union against it
    send_box(2000, 2000, 1984, 2100, 1'b0);          // zero width, zero area
    send_box(2000, 2000, 1984, 2100, 1'b0);          // zero union against it
    send_box(0, 0, 160, 160, 1'b1);                  // new set
    send_box(8, 8, 168, 168, 1'b0);                  // heavy overlap
    send_box(80, 0, 240, 160, 1'b0);                 // partial overlap

    // Zero threshold: any shared pixel suppresses; limit of two
    set_config(0, 2);
    send_box(0, 0, 160, 160, 1'b1);
    send_box(160, 0, 320, 160, 1'b0);
    send_box(1000, 1000, 1100, 1100, 1'b0);
    send_box(5000, 5000, 5100, 5100, 1'b0);          // limit reached

    // Limit zero: nothing is kept
    set_config(65535, 0);
    send_box(0, 0, 160, 160, 1'b1);
    send_box(-65536, 0, 65535, 16, 1'b0);

    // Top threshold with a limit above the list size
    set_config(65535, 127);
    send_box(-100, -100, 100, 100, 1'b1);
    send_box(-100, -100, 100, 100, 1'b0);            // full overlap still suppresses
    send_box(-99, -100, 100, 100, 1'b0);             // just under full overlap

    // Random phases, one setting each; the last one runs without idling
    for (p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0:       set_config(0, 1);
        1:       set_config(65535, 64);
        2:       set_config(rand_in(0, 65535), rand_in(1, 64));
        3:       set_config(32768, 127);
        4:       set_config(rand_in(0, 65535), 0);
        5:       set_config(rand_in(0, 65535), 65);
        6:       set_config(1, rand_in(1, 64));
        7:       set_config(rand_in(0, 65535), rand_in(0, 127));
        8:       set_config(rand_in(0, 4096), 64);
        default: set_config(rand_in(0, 65535), rand_in(1, 64));
      endcase
      gap_pct = (p == RAND_PHASES - 1) ? 0 : pick_pct();
      stall_pct = (p == RAND_PHASES - 1) ? 0 : pick_pct();
      if (p == 3)
        send_grid_set(72);
      if (p == 8) begin
        send_long_set();
      end else begin
        n = 0;
        while (n < PHASE_BOXES) begin
          k = rand_in(1, 30);
          send_random_set(k);
          n += k;
        end
      end
    end

    in_valid = 1'b0;
    wait_idle();
    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
